// File: hw/rtl/lzssd_pkg.sv
`timescale 1ns / 1ps

package lzssd_pkg;

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  localparam int unsigned DIST_W  = 12;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned MIN_RUN = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eos;
  } beat_t;

endpackage

// File: hw/rtl/lzssd_ram.sv
`timescale 1ns / 1ps

module lzssd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lzss_byte_decompressor_unit.sv
`timescale 1ns / 1ps

// LZSS decompressor with a WINDOW_SIZE-byte history window. One compressed
// byte is taken per input beat; flag bytes and low distance bytes yield no
// output, a literal yields one output beat, and a match yields length+2 beats
// (cut short at cfg out_length). Flag, low-distance and literal bytes are
// handled in the input state alone; after the high distance byte of a match,
// each copied byte is read from the window RAM (registered read) and then
// written back at the head before the next read, which keeps overlapping
// copies exact. Output back-pressure stalls the sequencer. Writing out_length
// restarts the stream; the window and its write position are kept.
// No clearing pass after reset.
module lzss_byte_decompressor_unit
  import lzssd_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // in_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tlast,   // last_of_run
  output logic             m_tuser,   // end_of_stream
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data   // out_length
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam logic [AW:0]   WIN  = (AW+1)'(WINDOW_SIZE);
  localparam logic [AW-1:0] WTOP = AW'(WINDOW_SIZE - 1);

  localparam logic [1:0] ST_IN = 2'd0;
  localparam logic [1:0] ST_RD = 2'd1;
  localparam logic [1:0] ST_WR = 2'd2;

  logic [1:0]        state, state_next;
  logic [1:0]        phase, phase_next;
  logic [7:0]        flag_bits, flag_bits_next;
  logic [3:0]        bits_left, bits_left_next;
  logic [7:0]        offset_low, offset_low_next;
  logic [DIST_W-1:0] match_dist, match_dist_next;
  logic [4:0]        remaining, remaining_next;
  logic [AW-1:0]     write_pos, write_pos_next;
  logic [LEN_W-1:0]  produced, produced_next;
  logic [LEN_W-1:0]  out_length, out_length_next;
  logic              finished, finished_next;

  beat_t             beat, beat_next;
  logic              beat_valid, beat_valid_next;

  logic              out_free;
  logic              in_fire;
  logic              emit_en;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic [LEN_W-1:0]  prod_inc;
  logic              emit_eos;

  logic [AW:0]       wp_ext, dist_ext;
  logic [AW:0]       src_ext;
  logic [AW-1:0]     src;
  logic [7:0]        rd_data;
  logic              rd_en;

  logic [7:0]        flag_shift;
  logic [3:0]        bits_dec;
  logic [1:0]        phase_tok;

  assign out_free  = !beat_valid || m_tready;
  assign s_tready  = (state == ST_IN) && out_free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = beat_valid;
  assign m_tdata  = beat.data;
  assign m_tlast  = beat.last;
  assign m_tuser  = beat.eos;

  assign wp_ext   = {1'b0, write_pos};
  assign dist_ext = (AW+1)'(match_dist);
  assign src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext) : (wp_ext + WIN - dist_ext);
  assign src      = src_ext[AW-1:0];
  assign rd_en    = (state == ST_RD);

  assign prod_inc = produced + LEN_W'(1);
  assign emit_eos = (prod_inc == out_length);

  // advance to the next token of the current flag byte
  assign flag_shift = {1'b0, flag_bits[7:1]};
  assign bits_dec   = bits_left - 4'd1;
  assign phase_tok  = (bits_dec == 4'd0) ? PH_FLAG : (flag_shift[0] ? PH_LIT : PH_LOW);

  lzssd_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SIZE)
  ) u_window (
    .clk    (clk),
    .wr_en  (emit_en),
    .wr_addr(write_pos),
    .wr_data(emit_byte),
    .rd_en  (rd_en),
    .rd_addr(src),
    .rd_data(rd_data)
  );

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    bits_left_next  = bits_left;
    offset_low_next = offset_low;
    match_dist_next = match_dist;
    remaining_next  = remaining;
    write_pos_next  = write_pos;
    produced_next   = produced;
    out_length_next = out_length;
    finished_next   = finished;
    emit_en         = 1'b0;
    emit_byte       = s_tdata;
    emit_last       = 1'b1;

    unique case (state)
      ST_IN: begin
        if (in_fire && !finished) begin
          unique case (phase)
            PH_FLAG: begin
              flag_bits_next = s_tdata;
              bits_left_next = 4'd8;
              phase_next     = s_tdata[0] ? PH_LIT : PH_LOW;
            end
            PH_LIT: begin
              emit_en        = 1'b1;
              flag_bits_next = flag_shift;
              bits_left_next = bits_dec;
              phase_next     = phase_tok;
            end
            PH_LOW: begin
              offset_low_next = s_tdata;
              phase_next      = PH_HIGH;
            end
            PH_HIGH: begin
              match_dist_next = {s_tdata[3:0], offset_low};
              remaining_next  = {1'b0, s_tdata[7:4]} + 5'(MIN_RUN);
              state_next      = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          emit_en        = 1'b1;
          emit_byte      = rd_data;
          emit_last      = (remaining == 5'd1) || emit_eos;
          remaining_next = remaining - 5'd1;
          if (emit_last) begin
            flag_bits_next = flag_shift;
            bits_left_next = bits_dec;
            phase_next     = phase_tok;
            state_next     = ST_IN;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      default: state_next = ST_IN;
    endcase

    if (emit_en) begin
      write_pos_next = (write_pos == WTOP) ? '0 : write_pos + AW'(1);
      produced_next  = prod_inc;
      if (emit_eos) begin
        finished_next = 1'b1;
      end
    end

    if (cfg_valid && cfg_ready) begin
      out_length_next = cfg_data;
      produced_next   = '0;
      flag_bits_next  = '0;
      bits_left_next  = '0;
      phase_next      = PH_FLAG;
      offset_low_next = '0;
      finished_next   = (cfg_data == '0);
      state_next      = ST_IN;
    end
  end

  always_comb begin
    beat_next       = beat;
    beat_valid_next = beat_valid;
    if (m_tready) begin
      beat_valid_next = 1'b0;
    end
    if (emit_en) begin
      beat_next.data  = emit_byte;
      beat_next.last  = emit_last;
      beat_next.eos   = emit_eos;
      beat_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IN;
      phase      <= PH_FLAG;
      flag_bits  <= '0;
      bits_left  <= '0;
      offset_low <= '0;
      remaining  <= '0;
      write_pos  <= '0;
      produced   <= '0;
      out_length <= LEN_W'(4096);
      finished   <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      bits_left  <= bits_left_next;
      offset_low <= offset_low_next;
      remaining  <= remaining_next;
      write_pos  <= write_pos_next;
      produced   <= produced_next;
      out_length <= out_length_next;
      finished   <= finished_next;
      beat_valid <= beat_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    match_dist <= match_dist_next;
    beat       <= beat_next;
  end

endmodule
